// ===== rtl/core/dnsqp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnsqp_pkg
// Types and constants shared by the DNS query parser.
// ----------------------------------------------------------------------------
package dnsqp_pkg;

    localparam int MAX_NAME_BYTES = 256;
    localparam int POS_W          = 9;
    localparam int RQ_AW          = 2;
    localparam int RQ_DEPTH       = 1 << RQ_AW;
    localparam int RQ_CW          = RQ_AW + 1;

    localparam logic [POS_W-1:0] NAME_LAST_POS = POS_W'(MAX_NAME_BYTES - 1);

    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7a;
    localparam logic [7:0] CHAR_DASH = 8'h2d;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_CHAR   = 3'd1,
        KIND_QDONE  = 3'd2,
        KIND_ACCEPT = 3'd3,
        KIND_REJECT = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ANSWERS = 2'd1,
        ST_LONG    = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_NAME   = 4'b0100,
        PH_TYPE   = 4'b1000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] message_id;
        logic        qr;
        logic [3:0]  opcode;
        logic [3:0]  flag_bits;
        logic [3:0]  rcode;
        logic [15:0] question_count;
        logic [7:0]  name_char;
        logic [15:0] query_type;
        logic [15:0] query_class;
        status_t     status;
    } result_t;

    localparam result_t RESULT_ZERO = '{
        kind: KIND_HEADER, message_id: 16'd0, qr: 1'b0, opcode: 4'd0,
        flag_bits: 4'd0, rcode: 4'd0, question_count: 16'd0, name_char: 8'd0,
        query_type: 16'd0, query_class: 16'd0, status: ST_OK
    };

endpackage : dnsqp_pkg
`default_nettype wire

// ===== rtl/core/dns_query_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_parser_top
// Byte-serial DNS query message parser with a small result queue.
// ----------------------------------------------------------------------------
// Takes one message byte per transaction on the s_ channel (s_tlast marks the
// final byte of a packet) and returns header, name character, question-done
// and verdict results on the m_ channel, kind in m_tuser. Each byte is parsed
// in the cycle it is accepted and its results land in a four-entry result
// queue, so one byte per cycle is taken while m_tready stays high. A byte
// that yields two results (header plus verdict, name character plus reject,
// question done plus verdict) fills two queue slots; s_tready drops when
// fewer than two slots are free, so throughput is set by the one-result-per-
// cycle drain of that queue.
// ----------------------------------------------------------------------------
module dns_query_parser_top
    import dnsqp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [15:0] message_id, [16] qr, [20:17] opcode,
                                        // [24:21] flag_bits, [28:25] rcode,
                                        // [44:29] question_count, [52:45] name_char,
                                        // [68:53] query_type, [84:69] query_class,
                                        // [86:85] status, [87] zero
    output logic [2:0]       m_tuser    // [2:0] kind
);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [47:0]      hdr_reg, hdr_next;
    logic             extra_reg, extra_next;
    logic [15:0]      qleft_reg, qleft_next;
    logic [31:0]      tc_reg, tc_next;
    logic             finished_reg, finished_next;

    result_t          rq_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [RQ_CW-1:0] count_reg;

    result_t          res0, res1;
    logic [1:0]       push_cnt;
    logic             s_fire, m_fire;
    logic [7:0]       b;
    logic             last;
    logic [15:0]      fl;
    logic [7:0]       dec_char;
    logic [31:0]      tc_shift;
    logic [15:0]      qleft_dec;
    result_t          head;

    assign s_tready = (count_reg <= RQ_CW'(RQ_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign b        = s_tdata;
    assign last     = s_tlast;
    assign fl       = hdr_reg[31:16];
    assign tc_shift = {tc_reg[23:0], b};
    assign qleft_dec = qleft_reg - 16'd1;
    assign dec_char = (((b >= CHAR_LC_A) && (b <= CHAR_LC_Z)) || (b == CHAR_DASH)) ?
                      b : CHAR_DOT;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        hdr_next      = hdr_reg;
        extra_next    = extra_reg;
        qleft_next    = qleft_reg;
        tc_next       = tc_reg;
        finished_next = finished_reg;
        res0          = RESULT_ZERO;
        res1          = RESULT_ZERO;
        push_cnt      = 2'd0;

        if (s_fire) begin
            if (finished_reg) begin
                if (last) begin
                    phase_next    = PH_HEADER;
                    pos_next      = '0;
                    hdr_next      = '0;
                    extra_next    = 1'b0;
                    qleft_next    = '0;
                    tc_next       = '0;
                    finished_next = 1'b0;
                end
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (pos_reg < POS_W'(6)) begin
                            hdr_next = {hdr_reg[39:0], b};
                        end else if ((pos_reg < POS_W'(10)) && (b != 8'd0)) begin
                            extra_next = 1'b1;
                        end
                        if (pos_reg < POS_W'(11)) begin
                            pos_next = pos_reg + POS_W'(1);
                            if (last) begin
                                res0.kind   = KIND_REJECT;
                                res0.status = ST_TRUNC;
                                push_cnt    = 2'd1;
                            end
                        end else begin
                            res0.kind           = KIND_HEADER;
                            res0.message_id     = hdr_reg[47:32];
                            res0.qr             = fl[15];
                            res0.opcode         = fl[14:11];
                            res0.flag_bits      = fl[10:7];
                            res0.rcode          = fl[3:0];
                            res0.question_count = hdr_reg[15:0];
                            push_cnt            = 2'd2;
                            if (extra_reg) begin
                                res1.kind     = KIND_REJECT;
                                res1.status   = ST_ANSWERS;
                                finished_next = 1'b1;
                            end else if (hdr_reg[15:0] == 16'd0) begin
                                res1.kind     = KIND_ACCEPT;
                                finished_next = 1'b1;
                            end else if (last) begin
                                res1.kind   = KIND_REJECT;
                                res1.status = ST_TRUNC;
                            end else begin
                                push_cnt   = 2'd1;
                                qleft_next = hdr_reg[15:0];
                                phase_next = PH_LENGTH;
                                pos_next   = '0;
                            end
                        end
                    end
                    PH_LENGTH: begin
                        phase_next = PH_NAME;
                        pos_next   = POS_W'(1);
                        if (last) begin
                            res0.kind   = KIND_REJECT;
                            res0.status = ST_TRUNC;
                            push_cnt    = 2'd1;
                        end
                    end
                    PH_NAME: begin
                        res0.kind = KIND_CHAR;
                        push_cnt  = 2'd1;
                        if (b == 8'd0) begin
                            res0.name_char = CHAR_DOT;
                            phase_next     = PH_TYPE;
                            pos_next       = '0;
                            tc_next        = '0;
                            if (last) begin
                                res1.kind   = KIND_REJECT;
                                res1.status = ST_TRUNC;
                                push_cnt    = 2'd2;
                            end
                        end else begin
                            res0.name_char = dec_char;
                            if (pos_reg >= NAME_LAST_POS) begin
                                res1.kind     = KIND_REJECT;
                                res1.status   = ST_LONG;
                                push_cnt      = 2'd2;
                                finished_next = 1'b1;
                            end else if (last) begin
                                res1.kind   = KIND_REJECT;
                                res1.status = ST_TRUNC;
                                push_cnt    = 2'd2;
                            end else begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end
                    end
                    PH_TYPE: begin
                        tc_next = tc_shift;
                        if (pos_reg < POS_W'(3)) begin
                            pos_next = pos_reg + POS_W'(1);
                            if (last) begin
                                res0.kind   = KIND_REJECT;
                                res0.status = ST_TRUNC;
                                push_cnt    = 2'd1;
                            end
                        end else begin
                            res0.kind        = KIND_QDONE;
                            res0.query_type  = tc_shift[31:16];
                            res0.query_class = tc_shift[15:0];
                            qleft_next       = qleft_dec;
                            push_cnt         = 2'd2;
                            if (qleft_dec == 16'd0) begin
                                res1.kind     = KIND_ACCEPT;
                                finished_next = 1'b1;
                            end else if (last) begin
                                res1.kind   = KIND_REJECT;
                                res1.status = ST_TRUNC;
                            end else begin
                                push_cnt   = 2'd1;
                                phase_next = PH_LENGTH;
                                pos_next   = '0;
                                tc_next    = '0;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                    end
                endcase

                // restart on the packet's final byte once the verdict is out
                if (last) begin
                    phase_next    = PH_HEADER;
                    pos_next      = '0;
                    hdr_next      = '0;
                    extra_next    = 1'b0;
                    qleft_next    = '0;
                    tc_next       = '0;
                    finished_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            hdr_reg      <= '0;
            extra_reg    <= 1'b0;
            qleft_reg    <= '0;
            tc_reg       <= '0;
            finished_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            hdr_reg      <= hdr_next;
            extra_reg    <= extra_next;
            qleft_reg    <= qleft_next;
            tc_reg       <= tc_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            rq_mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            rq_mem[wr_ptr_reg + RQ_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RQ_AW'(push_cnt);
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
            count_reg <= count_reg + RQ_CW'(push_cnt) - RQ_CW'(m_fire);
        end
    end

    assign head    = rq_mem[rd_ptr_reg];
    assign m_tuser = head.kind;
    assign m_tdata = {1'b0, head.status, head.query_class, head.query_type,
                      head.name_char, head.question_count, head.rcode,
                      head.flag_bits, head.opcode, head.qr, head.message_id};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RQ_CW'(RQ_DEPTH))
        else $error("result queue overflow");

    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && finished_reg) |-> (push_cnt == 2'd0))
        else $error("result produced after verdict");

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (phase_reg == PH_HEADER && !finished_reg &&
                                 pos_reg == '0))
        else $error("parser not re-armed after packet end");

endmodule : dns_query_parser_top
`default_nettype wire
